// ===== hdl/avellaneda_stoikov_quoter_assert.svh =====
// Assertion macros used by the checker file of the quoter.
// No dependencies; every macro expands to one labeled concurrent assertion.
`ifndef AVELLANEDA_STOIKOV_QUOTER_ASSERT_SVH
`define AVELLANEDA_STOIKOV_QUOTER_ASSERT_SVH

// same-cycle implication
`define ASQ_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define ASQ_ASSERT_LAT(lbl, ck, rn, ante, n, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ## n (cons)) \
		else $error(msg);

`endif

// ===== hdl/asq_pkg.sv =====
// Shared constants, types and helper functions of the quoter.
// No dependencies; imported by every module of the block.
package asq_pkg;

	localparam int FracBits = 16;
	localparam int PriceW   = 48;
	localparam int SpreadW  = 47;
	localparam int MarkupW  = PriceW + 1;
	localparam int ExtShift = 3 * FracBits;
	localparam int LnShift  = 57 - 2 * FracBits;
	localparam int QuotW    = 64 - LnShift;
	localparam int AddrW    = 3;

	localparam logic [63:0] Ln2Q64 = 64'hB17217F7D1CF79AB;
	localparam logic [PriceW:0] PriceCap = {1'b1, {PriceW{1'b0}}};

	localparam logic RegGamma     = 1'b0;
	localparam logic RegIntensity = 1'b1;

	typedef struct packed {
		logic              ovf;
		logic [PriceW-1:0] val;
	} sat_t;

	typedef struct packed {
		logic        go;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	// clamp to the signed price range
	function automatic sat_t sat_price(input logic signed [PriceW+1:0] v);
		sat_t r;
		r.ovf = 1'b0;
		r.val = v[PriceW-1:0];
		if (v > $signed({3'b000, {(PriceW-1){1'b1}}})) begin
			r.ovf = 1'b1;
			r.val = {1'b0, {(PriceW-1){1'b1}}};
		end else if (v < $signed({3'b111, {(PriceW-1){1'b0}}})) begin
			r.ovf = 1'b1;
			r.val = {1'b1, {(PriceW-1){1'b0}}};
		end
		return r;
	endfunction

	function automatic logic signed [PriceW+1:0] sext(input logic [PriceW-1:0] v);
		return $signed({{2{v[PriceW-1]}}, v});
	endfunction

	// drop the fraction of a triple product, cap at 2^48
	function automatic logic [PriceW:0] extract_window(input logic [159:0] w);
		logic [159:0] hi;
		hi = w >> (ExtShift + PriceW);
		if (hi != '0)
			return PriceCap;
		return {1'b0, w[ExtShift +: PriceW]};
	endfunction

endpackage

// ===== hdl/asq_mul64.sv =====
// Sequential 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on asq_pkg (request and response types).
module asq_mul64 import asq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         run_q;
	logic         ppv_q;
	logic [1:0]   ppi_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic         done_q;
	logic [31:0]  a_sel, b_sel;
	logic [127:0] pp_sh;

	assign a_sel = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_sel = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (ppi_q)
			2'd0:    pp_sh = {64'd0, pp_q};
			2'd3:    pp_sh = {pp_q, 64'd0};
			default: pp_sh = {32'd0, pp_q, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ppv_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			ppv_q  <= run_q;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd3)
					run_q <= 1'b0;
			end
			if (ppv_q && ppi_q == 2'd3)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pp_q  <= a_sel * b_sel;
		ppi_q <= cnt_q[1:0];
		if (req.go) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (ppv_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// ===== hdl/asq_markup.sv =====
// Markup engine: (2/gamma)*ln(1+gamma/k), recomputed after each register write.
// Depends on asq_pkg; drives the asq_mul64 instance for squarings and the ln2 scale.
module asq_markup import asq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [31:0]        gamma,
	input  logic [31:0]        intensity,
	output mul_req_t           mul_req,
	input  mul_rsp_t           mul_rsp,
	output logic               busy,
	output logic [MarkupW-1:0] markup
);

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StExp    = 3'd1;
	localparam logic [2:0] StDiv    = 3'd2;
	localparam logic [2:0] StSqGo   = 3'd3;
	localparam logic [2:0] StSqWait = 3'd4;
	localparam logic [2:0] StLnGo   = 3'd5;
	localparam logic [2:0] StLnWait = 3'd6;
	localparam logic [2:0] StQdiv   = 3'd7;

	logic [2:0]         state_q;
	logic [32:0]        num_q, d_q, rem_q;
	logic [5:0]         e_q, cnt_q, j_q;
	logic [61:0]        mq_q;
	logic [62:0]        m_q;
	logic [57:0]        frac_q;
	logic [QuotW-1:0]   dvd_q, quot_q;
	logic [31:0]        qrem_q;
	logic [MarkupW-1:0] markup_q;

	logic [33:0]      dsh2, r2;
	logic             mbit;
	logic [61:0]      nxt_mq;
	logic [63:0]      sq_t;
	logic [32:0]      trial;
	logic             qbit;
	logic [QuotW-1:0] qfin;

	assign dsh2   = {d_q, 1'b0};
	assign r2     = {rem_q, 1'b0};
	assign mbit   = r2 >= {1'b0, d_q};
	assign nxt_mq = {mq_q[60:0], mbit};
	assign sq_t   = mul_rsp.prod[125:62];
	assign trial  = {qrem_q, dvd_q[QuotW-1]};
	assign qbit   = trial >= {1'b0, gamma};
	assign qfin   = {quot_q[QuotW-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			markup_q <= '0;
		end else if (go) begin
			// any write restarts the run with both current register values
			if (gamma == 32'd0 || intensity == 32'd0) begin
				markup_q <= '0;
				state_q  <= StIdle;
			end else begin
				num_q   <= {1'b0, intensity} + {1'b0, gamma};
				d_q     <= {1'b0, intensity};
				e_q     <= '0;
				state_q <= StExp;
			end
		end else begin
			case (state_q)
				StIdle: state_q <= StIdle;
				// integer part of log2 of the ratio
				StExp: begin
					if (e_q < 6'd32 && dsh2 <= {1'b0, num_q}) begin
						d_q <= dsh2[32:0];
						e_q <= e_q + 6'd1;
					end else begin
						rem_q   <= num_q - d_q;
						mq_q    <= '0;
						cnt_q   <= '0;
						state_q <= StDiv;
					end
				end
				// mantissa by restoring division, one bit a cycle
				StDiv: begin
					rem_q <= mbit ? 33'(r2 - {1'b0, d_q}) : r2[32:0];
					mq_q  <= nxt_mq;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd61) begin
						m_q     <= {1'b1, nxt_mq};
						frac_q  <= '0;
						j_q     <= 6'd57;
						state_q <= StSqGo;
					end
				end
				StSqGo: state_q <= StSqWait;
				// fraction bits of log2 by repeated squaring
				StSqWait: begin
					if (mul_rsp.done) begin
						m_q         <= sq_t[63] ? sq_t[63:1] : sq_t[62:0];
						frac_q[j_q] <= sq_t[63];
						if (j_q == 6'd0) begin
							state_q <= StLnGo;
						end else begin
							j_q     <= j_q - 6'd1;
							state_q <= StSqGo;
						end
					end
				end
				StLnGo: state_q <= StLnWait;
				StLnWait: begin
					if (mul_rsp.done) begin
						dvd_q   <= mul_rsp.prod[127:64+LnShift];
						qrem_q  <= '0;
						quot_q  <= '0;
						cnt_q   <= '0;
						state_q <= StQdiv;
					end
				end
				// divide the scaled ln by gamma
				StQdiv: begin
					qrem_q <= qbit ? 32'(trial - {1'b0, gamma}) : trial[31:0];
					quot_q <= qfin;
					dvd_q  <= {dvd_q[QuotW-2:0], 1'b0};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'(QuotW - 1)) begin
						if (64'(qfin) > 64'(PriceCap))
							markup_q <= PriceCap;
						else
							markup_q <= MarkupW'(qfin);
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_comb begin
		mul_req.go = (state_q == StSqGo) || (state_q == StLnGo);
		mul_req.a  = (state_q == StLnGo) ? {e_q, frac_q} : {1'b0, m_q};
		mul_req.b  = (state_q == StLnGo) ? Ln2Q64 : {1'b0, m_q};
	end

	assign busy   = state_q != StIdle;
	assign markup = markup_q;

endmodule

// ===== hdl/asq_pipe.sv =====
// Eleven-stage quote pipeline: premium, skew, spread, quotes and distances.
// Depends on asq_pkg (widths, saturation and window helpers).
module asq_pipe import asq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [PriceW-1:0] mid_price,
	input  logic [31:0]              volatility,
	input  logic [31:0]              time_remaining,
	input  logic signed [31:0]       inventory,
	input  logic [31:0]              gamma,
	input  logic [MarkupW-1:0]       markup,
	input  logic                     degen,
	output logic                     out_valid,
	output logic signed [PriceW-1:0] resv_price,
	output logic signed [PriceW-1:0] inv_skew,
	output logic [SpreadW-1:0]       spread_total,
	output logic [SpreadW-1:0]       spread_half,
	output logic signed [PriceW-1:0] bid_quote,
	output logic signed [PriceW-1:0] ask_quote,
	output logic signed [PriceW-1:0] bid_distance,
	output logic signed [PriceW-1:0] ask_distance,
	output logic                     quote_valid
);

	logic [10:0] v_s;

	logic [PriceW-1:0] fv_s1, fv_s2, fv_s3, fv_s4, fv_s5, fv_s6, fv_s7, fv_s8, fv_s9, fv_s10;
	logic [31:0] s_s1, t_s1, t_s2, t_s3;
	logic [31:0] aq_s1, aq_s2, aq_s3, aq_s4, aq_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [63:0]  gs_s1, lo_s2, hi_s2;
	logic [95:0]  gss_s3;
	logic [63:0]  t0_s4, t1_s4, t2_s4;
	logic [127:0] w4_s5;
	logic [63:0]  u0_s6, u1_s6, u2_s6, u3_s6;
	logic [PriceW:0] prem_s6, prem_s7;
	logic [159:0] w5_s7;
	logic [PriceW-1:0] skew_s8, skew_s9, skew_s10;
	logic [SpreadW-1:0] total_s8, total_s9, total_s10;
	logic ok_s8, ok_s9, ok_s10;
	logic [PriceW-1:0] resv_s9, resv_s10;
	logic [PriceW-1:0] bid_s10, ask_s10;

	logic [PriceW-1:0] dbid_s11, dask_s11, resv_s11, skew_s11, bid_s11, ask_s11;
	logic [SpreadW-1:0] total_s11;
	logic ok_s11;

	logic [63:0]  gs;
	logic [31:0]  aq;
	logic [PriceW:0] mag;
	logic signed [PriceW+1:0] sk;
	logic [PriceW+1:0] sum;
	sat_t skew_sat, resv_sat, bid_sat, ask_sat, dbid_sat, dask_sat;
	logic [SpreadW-1:0] half_s9;

	assign gs  = gamma * volatility;
	assign aq  = inventory[31] ? 32'd0 - inventory : inventory;
	assign mag = extract_window(w5_s7);
	assign sk  = neg_s7 ? $signed((PriceW+2)'(0) - {1'b0, mag}) : $signed({1'b0, mag});
	assign sum = {1'b0, prem_s7} + {1'b0, markup};
	assign half_s9 = total_s9 >> 1;

	assign skew_sat = sat_price(sk);
	assign resv_sat = sat_price(sext(fv_s8) - sext(skew_s8));
	assign bid_sat  = sat_price(sext(resv_s9) - $signed({3'b000, half_s9}));
	assign ask_sat  = sat_price(sext(resv_s9) + $signed({3'b000, half_s9}));
	assign dbid_sat = sat_price(sext(fv_s10) - sext(bid_s10));
	assign dask_sat = sat_price(sext(ask_s10) - sext(fv_s10));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else
			v_s <= {v_s[9:0], in_valid};
	end

	always_ff @(posedge clk) begin
		// s1: capture, gamma*sigma
		fv_s1  <= mid_price;
		s_s1   <= volatility;
		t_s1   <= time_remaining;
		neg_s1 <= inventory[31];
		aq_s1  <= aq;
		gs_s1  <= gs;
		// s2: times sigma, two halves
		lo_s2  <= gs_s1[31:0] * s_s1;
		hi_s2  <= gs_s1[63:32] * s_s1;
		fv_s2  <= fv_s1;  t_s2 <= t_s1;  neg_s2 <= neg_s1;  aq_s2 <= aq_s1;
		// s3
		gss_s3 <= {32'd0, lo_s2} + {hi_s2, 32'd0};
		fv_s3  <= fv_s2;  t_s3 <= t_s2;  neg_s3 <= neg_s2;  aq_s3 <= aq_s2;
		// s4: times t
		t0_s4  <= gss_s3[31:0] * t_s3;
		t1_s4  <= gss_s3[63:32] * t_s3;
		t2_s4  <= gss_s3[95:64] * t_s3;
		fv_s4  <= fv_s3;  neg_s4 <= neg_s3;  aq_s4 <= aq_s3;
		// s5
		w4_s5  <= {64'd0, t0_s4} + {32'd0, t1_s4, 32'd0} + {t2_s4, 64'd0};
		fv_s5  <= fv_s4;  neg_s5 <= neg_s4;  aq_s5 <= aq_s4;
		// s6: times |inventory|, premium window
		u0_s6  <= w4_s5[31:0] * aq_s5;
		u1_s6  <= w4_s5[63:32] * aq_s5;
		u2_s6  <= w4_s5[95:64] * aq_s5;
		u3_s6  <= w4_s5[127:96] * aq_s5;
		prem_s6 <= extract_window({32'd0, w4_s5});
		fv_s6  <= fv_s5;  neg_s6 <= neg_s5;
		// s7
		w5_s7  <= {96'd0, u0_s6} + {64'd0, u1_s6, 32'd0} + {32'd0, u2_s6, 64'd0}
			+ {u3_s6, 96'd0};
		prem_s7 <= prem_s6;
		fv_s7  <= fv_s6;  neg_s7 <= neg_s6;
		// s8: skew and total spread
		skew_s8 <= skew_sat.val;
		if (sum > {3'b000, {SpreadW{1'b1}}}) begin
			total_s8 <= {SpreadW{1'b1}};
			ok_s8    <= 1'b0 & !skew_sat.ovf;
		end else begin
			total_s8 <= sum[SpreadW-1:0];
			ok_s8    <= !skew_sat.ovf;
		end
		fv_s8 <= fv_s7;
		// s9: reservation
		resv_s9  <= resv_sat.val;
		ok_s9    <= ok_s8 && !resv_sat.ovf;
		skew_s9  <= skew_s8;  total_s9 <= total_s8;  fv_s9 <= fv_s8;
		// s10: quotes
		bid_s10  <= bid_sat.val;
		ask_s10  <= ask_sat.val;
		ok_s10   <= ok_s9 && !bid_sat.ovf && !ask_sat.ovf;
		resv_s10 <= resv_s9;  skew_s10 <= skew_s9;  total_s10 <= total_s9;
		fv_s10   <= fv_s9;
		// s11: distances, degenerate config zeroes the beat
		if (degen) begin
			dbid_s11  <= '0;  dask_s11 <= '0;  resv_s11 <= '0;  skew_s11 <= '0;
			bid_s11   <= '0;  ask_s11  <= '0;  total_s11 <= '0;  ok_s11  <= 1'b0;
		end else begin
			dbid_s11  <= dbid_sat.val;
			dask_s11  <= dask_sat.val;
			resv_s11  <= resv_s10;
			skew_s11  <= skew_s10;
			bid_s11   <= bid_s10;
			ask_s11   <= ask_s10;
			total_s11 <= total_s10;
			ok_s11    <= ok_s10 && !dbid_sat.ovf && !dask_sat.ovf;
		end
	end

	assign out_valid    = v_s[10];
	assign resv_price   = resv_s11;
	assign inv_skew     = skew_s11;
	assign spread_total = total_s11;
	assign spread_half  = total_s11 >> 1;
	assign bid_quote    = bid_s11;
	assign ask_quote    = ask_s11;
	assign bid_distance = dbid_s11;
	assign ask_distance = dask_s11;
	assign quote_valid  = ok_s11;

endmodule

// ===== hdl/avellaneda_stoikov_quoter.sv =====
// Avellaneda-Stoikov quoter top: APB register file, markup engine, quote pipeline.
// Depends on asq_pkg, asq_mul64, asq_markup and asq_pipe.
//
// channel  | handshake                       | payload
// ---------+---------------------------------+-------------------------------------
// config   | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
// input    | start && !busy                  | mid_price, volatility, time, inventory
// result   | result_strobe, one cycle        | prices, spreads, distances, quote_valid
//
// One tick per cycle while busy is low; each accepted beat passes through the
// pipeline registers to result_strobe. After a register write, busy stays high
// while the markup engine runs (log2 by division and 58 squarings).
// Reset leaves both registers zero, so results are zero until both are written.
// The receiver cannot stall; the pipeline never holds.
module avellaneda_stoikov_quoter import asq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [AddrW-1:0]          paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [PriceW-1:0]  mid_price,
	input  logic [31:0]               volatility,
	input  logic [31:0]               time_remaining,
	input  logic signed [31:0]        inventory,
	output logic                      result_strobe,
	output logic signed [PriceW-1:0]  resv_price,
	output logic signed [PriceW-1:0]  inv_skew,
	output logic [SpreadW-1:0]        spread_total,
	output logic [SpreadW-1:0]        spread_half,
	output logic signed [PriceW-1:0]  bid_quote,
	output logic signed [PriceW-1:0]  ask_quote,
	output logic signed [PriceW-1:0]  bid_distance,
	output logic signed [PriceW-1:0]  ask_distance,
	output logic                      quote_valid
);

	logic [31:0] gamma_q, intensity_q;
	logic        cfg_wr_q;
	logic        wr;
	logic        eng_busy;
	logic [MarkupW-1:0] markup;
	mul_req_t    mul_req;
	mul_rsp_t    mul_rsp;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign prdata = (paddr[2] == RegIntensity) ? intensity_q : gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q     <= '0;
			intensity_q <= '0;
			cfg_wr_q    <= 1'b0;
		end else begin
			cfg_wr_q <= wr;
			if (wr && paddr[2] == RegGamma)
				gamma_q <= pwdata;
			if (wr && paddr[2] == RegIntensity)
				intensity_q <= pwdata;
		end
	end

	// engine starts the cycle after the write, once the new value sits in the register
	assign busy = eng_busy || cfg_wr_q;

	asq_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	asq_markup u_markup (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (cfg_wr_q),
		.gamma     (gamma_q),
		.intensity (intensity_q),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp),
		.busy      (eng_busy),
		.markup    (markup)
	);

	asq_pipe u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start && !busy),
		.mid_price      (mid_price),
		.volatility     (volatility),
		.time_remaining (time_remaining),
		.inventory      (inventory),
		.gamma          (gamma_q),
		.markup         (markup),
		.degen          (gamma_q == 32'd0 || intensity_q == 32'd0),
		.out_valid      (result_strobe),
		.resv_price     (resv_price),
		.inv_skew       (inv_skew),
		.spread_total   (spread_total),
		.spread_half    (spread_half),
		.bid_quote      (bid_quote),
		.ask_quote      (ask_quote),
		.bid_distance   (bid_distance),
		.ask_distance   (ask_distance),
		.quote_valid    (quote_valid)
	);

endmodule

// ===== hdl/asq_checker.sv =====
// Port-level checks of the quoter, bound to the top level.
// Depends on asq_pkg and avellaneda_stoikov_quoter_assert.svh.
`include "avellaneda_stoikov_quoter_assert.svh"

module asq_checker import asq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     result_strobe,
	input logic                     quote_valid,
	input logic [SpreadW-1:0]       spread_total,
	input logic [SpreadW-1:0]       spread_half,
	input logic signed [PriceW-1:0] bid_quote,
	input logic signed [PriceW-1:0] ask_quote
);

	// every accepted tick gives its beat after the fixed latency
	`ASQ_ASSERT_LAT(a_latency, clk, arst_n, start && !busy, 11, result_strobe, "missing result beat")

	`ASQ_ASSERT_IMPL(a_half, clk, arst_n, result_strobe, spread_half == (spread_total >> 1), "half spread mismatch")

	// no clamp means the quotes straddle the reservation price
	`ASQ_ASSERT_IMPL(a_order, clk, arst_n, result_strobe && quote_valid, bid_quote <= ask_quote, "bid above ask")

endmodule

bind avellaneda_stoikov_quoter asq_checker u_asq_checker (.*);
